### sv/slrdm_pkg.sv
`default_nettype none

package slrdm_pkg;

    // Scale constants for the time arithmetic
    localparam logic [29:0]        NS_PER_S     = 30'd1000000000;
    localparam logic signed [31:0] NS_PER_S_SGN = 32'sd1000000000;
    localparam logic signed [20:0] US_PER_S_SGN = 21'sd1000000;
    localparam logic [9:0]         NS_PER_US    = 10'd1000;

    // floor(2^40 / 1000); the quotient it gives is low by at most one
    localparam logic [30:0]        RECIP_1000   = 31'd1099511627;

    // Rate result and its bit-serial division
    localparam int                 RATE_W       = 48;
    localparam logic [RATE_W-1:0]  RATE_MAX     = {RATE_W{1'b1}};
    localparam int                 DIV_CNT_W    = $clog2(RATE_W);

    typedef struct packed {
        logic [63:0] sequence_req;
        logic [31:0] origin_sec;
        logic [29:0] origin_nsec;
        logic [31:0] arrival_sec;
        logic [29:0] arrival_nsec;
    } sample_t;

    typedef struct packed {
        logic signed [63:0] delay_us;
        logic signed [63:0] missed_count;
        logic [63:0]        out_of_order_count;
        logic [RATE_W-1:0]  rate_q16;
    } result_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_CHECK,
        S_DIV,
        S_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic stage1;
        logic stage2;
        logic stage3;
        logic check;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_done;
    } dp_status_t;

endpackage

`default_nettype wire

### sv/sequence_loss_rate_delay_monitor.sv
// Channel   Direction  Handshake                     Payload
// sample    in         sample_valid / sample_ready   slrdm_pkg::sample_t
// result    out        result_valid / result_ready   slrdm_pkg::result_t
//
// Steps: with a rate division, capture, three multiply steps, check,
//   the divider over 48 quotient bits and its hand-back, then output; the divider is skipped
//   without one (first sample, non-positive elapsed time or saturated rate).
// Reset: rst_n clears all statistics asynchronously; rate reads zero until the second sample.
// Stalls: a finished result waits in the output register while the next sample
//   is taken; a new result waits in its last step until that register is free.
`default_nettype none

module sequence_loss_rate_delay_monitor (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               sample_valid,
    output logic                    sample_ready,
    input  wire slrdm_pkg::sample_t sample,
    output logic                    result_valid,
    input  wire logic               result_ready,
    output slrdm_pkg::result_t      result
);
    import slrdm_pkg::*;

    // Command and status between sequencer and datapath
    ctrl_cmd_t  cmd;
    dp_status_t status;

    // Sequencer: capture, three multiply stages, check, divide when needed, hand off
    slrdm_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .cmd          (cmd)
    );

    // Datapath: delay in microseconds, loss and reorder counters, and the
    // Q32.16 rate from (received - 1) * 1e9 * 2^16 / elapsed nanoseconds
    slrdm_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample),
        .cmd    (cmd),
        .status (status),
        .result (result)
    );

endmodule

`default_nettype wire

### sv/slrdm_div.sv
`default_nettype none

module slrdm_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [63:0]                 rem_init,
    input  wire logic [slrdm_pkg::RATE_W-1:0] dividend_lo,
    input  wire logic [63:0]                 divisor,
    output logic                             done,
    output logic [slrdm_pkg::RATE_W-1:0]     quotient
);
    import slrdm_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [63:0]          rem_reg, rem_next;
    logic [RATE_W-1:0]    shift_reg, shift_next;
    logic [63:0]          divisor_reg, divisor_next;
    logic [63:0]          trial;
    logic                 fits;

    // Remainder stays below the divisor, which is below 2^63, so the top bit is free
    assign trial = {rem_reg[62:0], shift_reg[RATE_W-1]};
    assign fits  = trial >= divisor_reg;

    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        shift_next   = shift_reg;
        divisor_next = divisor_reg;
        if (start)
        begin
            busy_next    = 1'b1;
            cnt_next     = '0;
            rem_next     = rem_init;
            shift_next   = dividend_lo;
            divisor_next = divisor;
        end
        else if (busy_reg)
        begin
            rem_next   = fits ? (trial - divisor_reg) : trial;
            shift_next = {shift_reg[RATE_W-2:0], fits};
            cnt_next   = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(RATE_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg     <= cnt_next;
        rem_reg     <= rem_next;
        shift_reg   <= shift_next;
        divisor_reg <= divisor_next;
    end

    assign done     = done_reg;
    assign quotient = shift_reg;

endmodule

`default_nettype wire

### sv/slrdm_dp.sv
`default_nettype none

module slrdm_dp (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire slrdm_pkg::sample_t     sample,
    input  wire slrdm_pkg::ctrl_cmd_t   cmd,
    output slrdm_pkg::dp_status_t       status,
    output slrdm_pkg::result_t          result
);
    import slrdm_pkg::*;

    // Statistics state
    logic              seen_first_reg;
    logic [63:0]       received_count_reg;
    logic [31:0]       start_sec_reg;
    logic [29:0]       start_nsec_reg;
    logic [63:0]       first_seq_reg;
    logic [63:0]       highest_seq_reg;
    logic [63:0]       missed_total_reg;
    logic [63:0]       reorder_total_reg;
    logic [RATE_W-1:0] last_rate_reg;

    // Per-transaction working registers
    sample_t            smp_reg;
    logic [63:0]        cnt_m1_reg;
    logic signed [63:0] el_prod_reg;
    logic signed [30:0] el_dns_reg;
    logic [61:0]        num_lo_reg;
    logic [61:0]        num_hi_reg;
    logic [93:0]        num_reg;
    logic signed [63:0] elapsed_reg;
    logic signed [53:0] dus_reg;
    logic               neg_reg;
    logic [29:0]        abs_reg;
    logic [60:0]        recip_reg;
    logic [20:0]        q0_reg;
    logic [10:0]        rem1000_reg;
    logic signed [63:0] delay_reg;
    result_t            result_reg;

    logic signed [32:0] el_dsec;
    logic signed [30:0] el_dns;
    logic signed [32:0] dl_dsec;
    logic signed [30:0] dl_dns;
    logic [29:0]        dl_abs;
    logic [30:0]        r_full;
    logic [20:0]        q_fix;
    logic signed [63:0] dly_adj;
    logic signed [63:0] delay_next;
    logic               elapsed_pos;
    logic               rate_over;
    logic               need_div;
    logic               seq_gt;
    logic               div_done;
    logic [RATE_W-1:0]  div_quot;

    assign el_dsec = $signed({1'b0, smp_reg.arrival_sec}) - $signed({1'b0, start_sec_reg});
    assign el_dns  = $signed({1'b0, smp_reg.arrival_nsec}) - $signed({1'b0, start_nsec_reg});
    assign dl_dsec = $signed({1'b0, smp_reg.arrival_sec}) - $signed({1'b0, smp_reg.origin_sec});
    assign dl_dns  = $signed({1'b0, smp_reg.arrival_nsec}) - $signed({1'b0, smp_reg.origin_nsec});
    assign dl_abs  = dl_dns[30] ? 30'(-dl_dns) : dl_dns[29:0];

    // Remainder of the reciprocal estimate, known to lie in [0, 2000)
    assign r_full  = {1'b0, abs_reg} - q0_reg * NS_PER_US;

    // Truncate toward zero: correct the magnitude, then reapply the sign
    assign q_fix      = q0_reg + 21'(rem1000_reg >= 11'(NS_PER_US));
    assign dly_adj    = neg_reg ? -(64'(q_fix)) : 64'(q_fix);
    assign delay_next = {{10{dus_reg[53]}}, dus_reg} + dly_adj;

    // Quotient exceeds 48 bits exactly when the dividend's upper bits reach the divisor
    assign elapsed_pos = !elapsed_reg[63] && (elapsed_reg != 64'sd0);
    assign rate_over   = 64'(num_reg[93:32]) >= $unsigned(elapsed_reg);
    assign need_div    = seen_first_reg && elapsed_pos && !rate_over;

    assign seq_gt = smp_reg.sequence_req > highest_seq_reg;

    slrdm_div u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (cmd.check && need_div),
        .rem_init    (64'(num_reg[93:32])),
        .dividend_lo ({num_reg[31:0], 16'b0}),
        .divisor     ($unsigned(elapsed_reg)),
        .done        (div_done),
        .quotient    (div_quot)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            smp_reg    <= sample;
            cnt_m1_reg <= received_count_reg;
        end
        if (cmd.stage1)
        begin
            el_prod_reg <= el_dsec * NS_PER_S_SGN;
            el_dns_reg  <= el_dns;
            num_lo_reg  <= cnt_m1_reg[31:0] * NS_PER_S;
            dus_reg     <= dl_dsec * US_PER_S_SGN;
            neg_reg     <= dl_dns[30];
            abs_reg     <= dl_abs;
            recip_reg   <= dl_abs * RECIP_1000;
        end
        if (cmd.stage2)
        begin
            elapsed_reg <= el_prod_reg + {{33{el_dns_reg[30]}}, el_dns_reg};
            num_hi_reg  <= cnt_m1_reg[63:32] * NS_PER_S;
            q0_reg      <= recip_reg[60:40];
        end
        if (cmd.stage3)
        begin
            num_reg     <= {num_hi_reg, 32'b0} + 94'(num_lo_reg);
            rem1000_reg <= r_full[10:0];
        end
        if (cmd.check)
        begin
            delay_reg <= delay_next;
        end
        if (cmd.load_out)
        begin
            result_reg.delay_us           <= delay_reg;
            result_reg.missed_count       <= missed_total_reg;
            result_reg.out_of_order_count <= reorder_total_reg;
            result_reg.rate_q16           <= last_rate_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_first_reg     <= 1'b0;
            received_count_reg <= '0;
            start_sec_reg      <= '0;
            start_nsec_reg     <= '0;
            first_seq_reg      <= '0;
            highest_seq_reg    <= '0;
            missed_total_reg   <= '0;
            reorder_total_reg  <= '0;
            last_rate_reg      <= '0;
        end
        else
        begin
            if (cmd.capture)
            begin
                received_count_reg <= received_count_reg + 64'd1;
            end
            if (cmd.check)
            begin
                if (!seen_first_reg)
                begin
                    seen_first_reg    <= 1'b1;
                    start_sec_reg     <= smp_reg.arrival_sec;
                    start_nsec_reg    <= smp_reg.arrival_nsec;
                    first_seq_reg     <= smp_reg.sequence_req;
                    highest_seq_reg   <= smp_reg.sequence_req;
                    missed_total_reg  <= '0;
                    reorder_total_reg <= '0;
                end
                else
                begin
                    if (!need_div)
                    begin
                        last_rate_reg <= RATE_MAX;
                    end
                    if (seq_gt)
                    begin
                        missed_total_reg <= missed_total_reg
                                          + (smp_reg.sequence_req - highest_seq_reg - 64'd1);
                        highest_seq_reg  <= smp_reg.sequence_req;
                    end
                    else
                    begin
                        if (smp_reg.sequence_req >= first_seq_reg)
                        begin
                            missed_total_reg <= missed_total_reg - 64'd1;
                        end
                        reorder_total_reg <= reorder_total_reg + 64'd1;
                    end
                end
            end
            if (div_done)
            begin
                last_rate_reg <= div_quot;
            end
        end
    end

    assign status.need_div = need_div;
    assign status.div_done = div_done;
    assign result          = result_reg;

endmodule

`default_nettype wire

### sv/slrdm_ctrl.sv
`default_nettype none

module slrdm_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   sample_valid,
    output logic                        sample_ready,
    output logic                        result_valid,
    input  wire logic                   result_ready,
    input  wire slrdm_pkg::dp_status_t  status,
    output slrdm_pkg::ctrl_cmd_t        cmd
);
    import slrdm_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        result_valid_reg, result_valid_next;
    logic        out_free;

    assign out_free = !result_valid_reg || result_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (sample_valid)
                begin
                    state_next = S_MUL1;
                end
            end
            S_MUL1:  state_next = S_MUL2;
            S_MUL2:  state_next = S_MUL3;
            S_MUL3:  state_next = S_CHECK;
            S_CHECK: state_next = status.need_div ? S_DIV : S_OUT;
            S_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        sample_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                sample_ready = 1'b1;
                cmd.capture  = sample_valid;
            end
            S_MUL1:  cmd.stage1   = 1'b1;
            S_MUL2:  cmd.stage2   = 1'b1;
            S_MUL3:  cmd.stage3   = 1'b1;
            S_CHECK: cmd.check    = 1'b1;
            S_OUT:   cmd.load_out = out_free;
            default: cmd          = '0;
        endcase
        if (cmd.load_out)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign result_valid = result_valid_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!result_valid_reg || result_ready))
        else $error("pending result overwritten");

    a_skip_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK && !status.need_div) |=> (state_reg == S_OUT))
        else $error("no-division path did not go to output");

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        status.div_done |-> (state_reg == S_DIV))
        else $error("division finished outside the division state");

    a_div_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && !status.div_done) |=> (state_reg == S_DIV))
        else $error("left the division state early");

endmodule

`default_nettype wire
